FILE: rtl/awc_pkg.sv
// Shared types and constants for the anagram window counter.
// Holds the command codes, stream field widths and the stage-one control struct.
// No dependencies; used by the top level and its checker.
`default_nettype none

package awc_pkg;

	// Command carried on the slave tuser lane.
	localparam int OP_W = 2;
	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_CLEAR   = 2'd0;
	localparam op_t OP_PATTERN = 2'd1;
	localparam op_t OP_TEXT    = 2'd2;

	// Letter index field and the slave tdata width (rounded up to whole bytes).
	localparam int LETTER_W    = 5;
	localparam int IN_DATA_W   = ((LETTER_W + 7) / 8) * 8;

	typedef logic [LETTER_W-1:0] letter_t;

	// Control that travels with a beat from the front stage into stage one.
	typedef struct packed {
		op_t     op;
		letter_t letter;
		logic    add_pattern;
		logic    leave;
		logic    k_zero;
		logic    window_full;
	} s1_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/anagram_window_count.sv
// An accepted command beat is held in the stage-one register, then its result beat in the
// output register; it waits in stage one while the output register holds an untaken beat.
// Throughput: one beat per cycle; the slave side takes a new beat every cycle unless both the
// stage-one register and the output register hold beats that the master side has not taken.
// Reset (arst_n low) clears the counters, both histograms, the match total and all valid flags.
// The ring of recent letters is not cleared; only slots written since the last clear are read.
// A clear command resets the counters, histograms and match total through the beat flow.
`default_nettype none

// Top level of the anagram window counter. Depends on awc_pkg.
// Front stage keeps counters and the letter ring; stage one keeps histograms and the total.
module anagram_window_count #(
	parameter int MAX_PATTERN      = 64,
	parameter int ALPHABET         = 26,
	parameter int MATCH_COUNT_BITS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// Slave side: one command beat per handshake.
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [awc_pkg::OP_W-1:0]         s_tuser,  // op
	input  wire  [awc_pkg::IN_DATA_W-1:0]    s_tdata,  // letter, then zero fill
	// Master side: one result beat per command beat.
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [((2 + MATCH_COUNT_BITS + 7) / 8) * 8 - 1:0] m_tdata
	// m_tdata: window_full, is_match, match_total, then zero fill
);

	// Histogram bins saturate at twice the longest pattern minus one.
	localparam int HIST_W   = $clog2(2 * MAX_PATTERN);
	localparam int HIST_MAX = 2 * MAX_PATTERN - 1;
	// Pattern length and letters seen both run from 0 to MAX_PATTERN.
	localparam int LEN_W    = $clog2(MAX_PATTERN + 1);
	localparam int PTR_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int SUM_W    = LEN_W + 1;

	// ------------------------------------------------------------------
	// Handshake and stage flow.
	// Stage one advances into the output register whenever that register
	// is empty or being drained. The slave side is ready whenever stage
	// one is empty or advancing, so beats flow one per cycle.
	// ------------------------------------------------------------------
	logic s1_valid_q;
	logic out_valid_q;
	logic out_free;
	logic advance;
	logic accept;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = s1_valid_q && out_free;
	assign s_tready = !s1_valid_q || out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Front stage: pattern length, letters seen and the ring pointer are
	// updated as each beat is accepted, so the ring slot of the letter
	// that leaves the window can be read right away.
	// ------------------------------------------------------------------
	awc_pkg::op_t     in_op;
	awc_pkg::letter_t in_letter;
	logic             letter_ok;

	assign in_op     = awc_pkg::op_t'(s_tuser);
	assign in_letter = s_tdata[awc_pkg::LETTER_W-1:0];
	assign letter_ok = int'(in_letter) < ALPHABET;

	logic [LEN_W-1:0] plen_q;
	logic [LEN_W-1:0] seen_q;
	logic [PTR_W-1:0] ptr_q;

	logic [LEN_W-1:0] plen_nx;
	logic [LEN_W-1:0] seen_nx;
	logic [PTR_W-1:0] ptr_nx;
	logic             add_pattern;
	logic             leave;
	logic [SUM_W-1:0] ptr_ext;
	logic [SUM_W-1:0] k_ext;
	logic [SUM_W-1:0] slot_wide;
	logic [PTR_W-1:0] slot;

	// Slot of the letter k places back, modulo the ring depth.
	assign ptr_ext   = SUM_W'(ptr_q);
	assign k_ext     = SUM_W'(plen_q);
	assign slot_wide = (ptr_ext >= k_ext) ? (ptr_ext - k_ext)
	                                      : (ptr_ext + SUM_W'(MAX_PATTERN) - k_ext);
	assign slot      = slot_wide[PTR_W-1:0];

	assign add_pattern = letter_ok && (plen_q < LEN_W'(MAX_PATTERN));
	assign leave       = seen_q >= plen_q;

	always_comb begin
		plen_nx = plen_q;
		seen_nx = seen_q;
		ptr_nx  = ptr_q;
		case (in_op)
			awc_pkg::OP_CLEAR: begin
				plen_nx = '0;
				seen_nx = '0;
				ptr_nx  = '0;
			end
			awc_pkg::OP_PATTERN: begin
				if (add_pattern) begin
					plen_nx = plen_q + LEN_W'(1);
				end
			end
			awc_pkg::OP_TEXT: begin
				if (seen_q < LEN_W'(MAX_PATTERN)) begin
					seen_nx = seen_q + LEN_W'(1);
				end
				ptr_nx = (ptr_q == PTR_W'(MAX_PATTERN - 1)) ? '0 : (ptr_q + PTR_W'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			seen_q <= '0;
			ptr_q  <= '0;
		end else if (accept) begin
			plen_q <= plen_nx;
			seen_q <= seen_nx;
			ptr_q  <= ptr_nx;
		end
	end

	// Ring of recent letters. When the pattern fills the whole ring, the slot
	// read is the slot being written; the read still returns the letter stored
	// there before this beat, which is exactly the letter that leaves.
	awc_pkg::letter_t ring_mem [MAX_PATTERN];
	awc_pkg::letter_t old_letter_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			if (in_op == awc_pkg::OP_TEXT) begin
				ring_mem[ptr_q] <= in_letter;
			end
			old_letter_s1 <= ring_mem[slot];
		end
	end

	// Control for stage one. The window-full flag reflects the counters
	// after this beat, which is what the result reports.
	awc_pkg::s1_ctl_t ctl_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.op          <= in_op;
			ctl_s1.letter      <= in_letter;
			ctl_s1.add_pattern <= add_pattern;
			ctl_s1.leave       <= leave;
			ctl_s1.k_zero      <= (plen_q == '0);
			ctl_s1.window_full <= (seen_nx >= plen_nx);
		end
	end

	// ------------------------------------------------------------------
	// Stage one: per-letter histogram cells. Each bin adds the incoming
	// letter first (saturating), then removes the leaving letter (floored
	// at zero), and compares itself against the pattern bin.
	// ------------------------------------------------------------------
	awc_pkg::letter_t rem_letter;
	logic             is_text;
	logic [ALPHABET-1:0] bin_eq;

	assign rem_letter = ctl_s1.k_zero ? ctl_s1.letter : old_letter_s1;
	assign is_text    = (ctl_s1.op == awc_pkg::OP_TEXT);

	logic [HIST_W-1:0] win_q [ALPHABET];
	logic [HIST_W-1:0] pat_q [ALPHABET];

	for (genvar j = 0; j < ALPHABET; j++) begin : g_bin
		logic              add_hit;
		logic              rem_hit;
		logic [HIST_W-1:0] win_add;
		logic [HIST_W-1:0] win_nx;

		assign add_hit = is_text && (int'(ctl_s1.letter) == j);
		assign rem_hit = ctl_s1.leave && (int'(rem_letter) == j);
		assign win_add = (add_hit && (win_q[j] < HIST_W'(HIST_MAX)))
		                 ? (win_q[j] + HIST_W'(1)) : win_q[j];
		assign win_nx  = (rem_hit && (win_add != '0)) ? (win_add - HIST_W'(1)) : win_add;
		assign bin_eq[j] = (win_nx == pat_q[j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				win_q[j] <= '0;
				pat_q[j] <= '0;
			end else if (advance) begin
				case (ctl_s1.op)
					awc_pkg::OP_CLEAR: begin
						win_q[j] <= '0;
						pat_q[j] <= '0;
					end
					awc_pkg::OP_PATTERN: begin
						if (ctl_s1.add_pattern && (int'(ctl_s1.letter) == j)) begin
							pat_q[j] <= pat_q[j] + HIST_W'(1);
						end
					end
					awc_pkg::OP_TEXT: begin
						win_q[j] <= win_nx;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Match decision and the saturating total.
	logic                        hit;
	logic [MATCH_COUNT_BITS-1:0] count_q;
	logic [MATCH_COUNT_BITS-1:0] count_nx;

	assign hit = is_text && ctl_s1.window_full && (&bin_eq);

	always_comb begin
		count_nx = count_q;
		if (ctl_s1.op == awc_pkg::OP_CLEAR) begin
			count_nx = '0;
		end else if (hit && (count_q != '1)) begin
			count_nx = count_q + MATCH_COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= count_nx;
		end
	end

	// ------------------------------------------------------------------
	// Output register. It holds a finished beat while the master side
	// stalls; stage one can still take a beat if it is empty.
	// ------------------------------------------------------------------
	logic                        full_q;
	logic                        match_q;
	logic [MATCH_COUNT_BITS-1:0] total_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			full_q  <= ctl_s1.window_full;
			match_q <= hit;
			total_q <= count_nx;
		end
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[0] = full_q;
		m_tdata[1] = match_q;
		m_tdata[2 +: MATCH_COUNT_BITS] = total_q;
	end

endmodule

`default_nettype wire

FILE: rtl/awc_checker.sv
// Port-level checker for the anagram window counter, bound to the top level.
// Depends on awc_pkg for the slave field widths.
`default_nettype none

module awc_checker #(
	parameter int MATCH_COUNT_BITS = 16
) (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           s_tvalid,
	input wire                           s_tready,
	input wire [awc_pkg::OP_W-1:0]       s_tuser,
	input wire [awc_pkg::IN_DATA_W-1:0]  s_tdata,
	input wire                           m_tvalid,
	input wire                           m_tready,
	input wire [((2 + MATCH_COUNT_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

	logic in_beat;
	assign in_beat = s_tvalid && s_tready;

	// A command beat carries known fields.
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid |-> !$isunknown({s_tuser, s_tdata}))
		else $error("command beat with unknown fields");

	// A stalled result beat keeps its valid and its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// With the output register empty nothing can block the slave side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("slave side not ready with an empty output");

	// A new result beat follows a command beat through the stage-one register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(in_beat, 2))
		else $error("result beat without a matching command beat");

	// A match needs a full window and leaves a non-zero total.
	a_match_sane: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0] && (m_tdata[2 +: MATCH_COUNT_BITS] != '0))
		else $error("match reported without a full window or a total");

endmodule

bind anagram_window_count awc_checker #(
	.MATCH_COUNT_BITS (MATCH_COUNT_BITS)
) u_awc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
